### design/isl_pkg.sv
`default_nettype none
package isl_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int ID_W      = 32;
  localparam int HINT_W    = ID_W + 1;
  localparam int SLOT_IO_W = 11;
  localparam int LIVE_W    = 11;

  localparam logic [CNT_W-1:0] SLOT_CAP = CNT_W'(MAX_SLOTS);
  localparam logic signed [HINT_W-1:0] ID_LIMIT = {2'b00, {(ID_W-1){1'b1}}};
  localparam logic signed [HINT_W-1:0] HINT_ONE = HINT_W'(1);

  typedef enum logic [3:0] {
    OP_CREATE_NEXT    = 4'd0,
    OP_CREATE_ID      = 4'd1,
    OP_FIND_OR_CREATE = 4'd2,
    OP_FIND           = 4'd3,
    OP_REMOVE_SLOT    = 4'd4,
    OP_REMOVE_ID      = 4'd5,
    OP_READ_ID        = 4'd6,
    OP_FIRST          = 4'd7,
    OP_NEXT           = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_IN_USE   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_START,
    FSM_HINT,
    FSM_LOOKUP,
    FSM_RDWAIT,
    FSM_ORDER,
    FSM_MAXSCAN,
    FSM_EMIT
  } fsm_e;

endpackage
`default_nettype wire

### design/isl_ram.sv
`default_nettype none
module isl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### design/identifier_slot_table_core.sv
// Channel | Dir | Valid / stall             | Beat fields
// in      | in  | in_valid_i / in_stall_o   | op, key_id, slot_in
// out     | out | out_valid_o / out_stall_i | status, slot_out, id_out, live_count
//
// One beat at a time: in_stall_o is high from the taking of an input beat until its result is
// loaded into the result register. Unknown ops, negative keys, bad slots, first on an empty table
// and create_next on the contiguous run go straight to the result; read_id, remove_slot read a slot.
// Searches read one stored slot per cycle over all used slots for lookups and first; next reads its
// own slot first. Removing the highest identifier, unless it was the last, adds a rescan for the
// new highest, and create_next off the run scans the table once per identifier tried. Reset clears control
// state only; a stalled result holds the core until it is taken.
`default_nettype none
module identifier_slot_table_core import isl_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [3:0]                  in_op_i,
  input  wire logic signed [ID_W-1:0]      in_key_id_i,
  input  wire logic signed [SLOT_IO_W-1:0] in_slot_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       out_status_o,
  output logic signed [SLOT_IO_W-1:0]      out_slot_out_o,
  output logic signed [ID_W-1:0]           out_id_out_o,
  output logic [LIVE_W-1:0]                out_live_count_o
);

  fsm_e state_q, state_d;

  op_e                          op_q, op_d;
  logic signed [ID_W-1:0]       key_q, key_d;
  logic signed [SLOT_IO_W-1:0]  sin_q, sin_d;

  logic [CNT_W-1:0]             used_q, used_d;
  logic [LIVE_W-1:0]            live_q, live_d;
  logic signed [ID_W-1:0]       low_q, low_d;
  logic signed [ID_W-1:0]       high_q, high_d;
  logic signed [HINT_W-1:0]     hint_q, hint_d;
  logic                         dense_q, dense_d;

  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         pend_q, pend_d;
  logic [SLOT_W-1:0]            pidx_q, pidx_d;
  logic                         found_q, found_d;
  logic [SLOT_W-1:0]            fidx_q, fidx_d;
  logic signed [ID_W-1:0]       fval_q, fval_d;
  logic signed [HINT_W-1:0]     floor_q, floor_d;

  status_e                      res_status_q, res_status_d;
  logic signed [SLOT_IO_W-1:0]  res_slot_q, res_slot_d;
  logic signed [ID_W-1:0]       res_id_q, res_id_d;

  logic                         out_valid_q, out_valid_d;
  status_e                      out_status_q, out_status_d;
  logic signed [SLOT_IO_W-1:0]  out_slot_q, out_slot_d;
  logic signed [ID_W-1:0]       out_id_q, out_id_d;
  logic [LIVE_W-1:0]            out_live_q, out_live_d;

  logic                         mem_we;
  logic [SLOT_W-1:0]            mem_waddr;
  logic [ID_W-1:0]              mem_wdata;
  logic [SLOT_W-1:0]            mem_raddr;
  logic [ID_W-1:0]              mem_rdata_raw;
  logic signed [ID_W-1:0]       rdata;

  logic signed [HINT_W-1:0]     key33, rd33, high33, low33, tgt, add_id, drop_val33;
  logic                         sin_ok, scan_issue, scan_done, hit, better;
  logic                         add_bad, add_full, add_leave, out_free;
  logic [SLOT_W-1:0]            drop_slot;
  logic signed [ID_W-1:0]       drop_val;
  logic                         drop_last, drop_rescan, in_accept;
  logic                         do_add, do_drop;

  isl_ram #(.WIDTH(ID_W), .DEPTH(MAX_SLOTS)) u_ids (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata_raw)
  );

  assign rdata      = $signed(mem_rdata_raw);
  assign in_stall_o = (state_q != FSM_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    key33      = {key_q[ID_W-1], key_q};
    rd33       = {rdata[ID_W-1], rdata};
    high33     = {high_q[ID_W-1], high_q};
    low33      = {low_q[ID_W-1], low_q};
    sin_ok     = !sin_q[SLOT_IO_W-1] &&
                 ({1'b0, sin_q[SLOT_W-1:0]} < used_q);
    scan_issue = (cnt_q < used_q);
    scan_done  = !scan_issue && !pend_q;
    tgt        = (state_q == FSM_HINT) ? hint_q : key33;
    hit        = pend_q && (rd33 == tgt);
    better     = pend_q && !rdata[ID_W-1] && (rd33 > floor_q) &&
                 (!found_q || (rdata < fval_q));
    drop_slot  = (state_q == FSM_LOOKUP) ? fidx_q : sin_q[SLOT_W-1:0];
    drop_val   = (state_q == FSM_LOOKUP) ? key_q : rdata;
    drop_val33 = {drop_val[ID_W-1], drop_val};
    drop_last  = (live_q == LIVE_W'(1));
    drop_rescan = (drop_val == high_q) && !drop_last;
    add_id     = (op_q == OP_CREATE_NEXT) ? hint_q : key33;
    add_bad    = add_id[HINT_W-1] || (add_id > ID_LIMIT);
    add_full   = (used_q >= SLOT_CAP);
    add_leave  = dense_q && (live_q != '0) &&
                 ((add_id < low33) || (add_id > high33 + HINT_ONE));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_accept) state_d = FSM_START;
      end
      FSM_START: begin
        case (op_q) inside
          OP_CREATE_NEXT: state_d = (hint_q == high33 + HINT_ONE) ? FSM_EMIT : FSM_HINT;
          OP_CREATE_ID, OP_FIND_OR_CREATE, OP_FIND, OP_REMOVE_ID:
            state_d = key_q[ID_W-1] ? FSM_EMIT : FSM_LOOKUP;
          OP_REMOVE_SLOT, OP_READ_ID, OP_NEXT:
            state_d = sin_ok ? FSM_RDWAIT : FSM_EMIT;
          OP_FIRST: state_d = (live_q != '0) ? FSM_ORDER : FSM_EMIT;
          default: state_d = FSM_EMIT;
        endcase
      end
      FSM_HINT: begin
        if (scan_done) state_d = found_q ? FSM_HINT : FSM_EMIT;
      end
      FSM_LOOKUP: begin
        if (scan_done) begin
          state_d = (found_q && op_q == OP_REMOVE_ID && drop_rescan) ?
                    FSM_MAXSCAN : FSM_EMIT;
        end
      end
      FSM_RDWAIT: begin
        state_d = FSM_EMIT;
        if (!rdata[ID_W-1]) begin
          if (op_q == OP_REMOVE_SLOT && drop_rescan) state_d = FSM_MAXSCAN;
          if (op_q == OP_NEXT) state_d = FSM_ORDER;
        end
      end
      FSM_ORDER, FSM_MAXSCAN: begin
        if (scan_done) state_d = FSM_EMIT;
      end
      FSM_EMIT: begin
        if (out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_d = op_q;   key_d = key_q;   sin_d = sin_q;
    used_d = used_q; live_d = live_q; low_d = low_q; high_d = high_q;
    hint_d = hint_q; dense_d = dense_q;
    cnt_d = cnt_q; pend_d = pend_q; pidx_d = pidx_q;
    found_d = found_q; fidx_d = fidx_q; fval_d = fval_q; floor_d = floor_q;
    res_status_d = res_status_q; res_slot_d = res_slot_q; res_id_d = res_id_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_status_d = out_status_q; out_slot_d = out_slot_q;
    out_id_d = out_id_q; out_live_d = out_live_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    mem_raddr = (state_q == FSM_START) ? sin_q[SLOT_W-1:0] : cnt_q[SLOT_W-1:0];
    do_add = 1'b0; do_drop = 1'b0;

    if (state_q == FSM_HINT || state_q == FSM_LOOKUP ||
        state_q == FSM_ORDER || state_q == FSM_MAXSCAN) begin
      if (scan_issue) begin
        cnt_d  = cnt_q + CNT_W'(1);
        pend_d = 1'b1;
        pidx_d = cnt_q[SLOT_W-1:0];
      end else begin
        pend_d = 1'b0;
      end
    end

    case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          op_d  = op_e'(in_op_i);
          key_d = in_key_id_i;
          sin_d = in_slot_in_i;
        end
      end
      FSM_START: begin
        res_status_d = ST_NOTFOUND;
        res_slot_d   = '1;
        res_id_d     = '1;
        cnt_d        = '0;
        pend_d       = 1'b0;
        found_d      = 1'b0;
        floor_d      = '1;
        if (op_q == OP_CREATE_NEXT && hint_q == high33 + HINT_ONE) do_add = 1'b1;
        if (op_q == OP_REMOVE_SLOT && sin_ok) dense_d = 1'b0;
      end
      FSM_HINT: begin
        if (hit && !found_q) found_d = 1'b1;
        if (scan_done) begin
          if (found_q) begin
            // The hinted identifier is taken; try the one after it.
            hint_d  = hint_q + HINT_ONE;
            cnt_d   = '0;
            found_d = 1'b0;
          end else begin
            do_add = 1'b1;
          end
        end
      end
      FSM_LOOKUP: begin
        if (hit && !found_q) begin
          found_d = 1'b1;
          fidx_d  = pidx_q;
        end
        if (scan_done) begin
          case (op_q) inside
            OP_CREATE_ID: begin
              if (found_q) res_status_d = ST_IN_USE;
              else do_add = 1'b1;
            end
            OP_FIND_OR_CREATE, OP_FIND: begin
              if (found_q) begin
                res_status_d = ST_OK;
                res_slot_d   = SLOT_IO_W'({1'b0, fidx_q});
                res_id_d     = key_q;
              end else if (op_q == OP_FIND_OR_CREATE) begin
                do_add = 1'b1;
              end
            end
            OP_REMOVE_ID: begin
              if (found_q) do_drop = 1'b1;
            end
            default: ;
          endcase
        end
      end
      FSM_RDWAIT: begin
        if (!rdata[ID_W-1]) begin
          case (op_q)
            OP_REMOVE_SLOT: do_drop = 1'b1;
            OP_READ_ID: begin
              res_status_d = ST_OK;
              res_slot_d   = sin_q;
              res_id_d     = rdata;
            end
            OP_NEXT: begin
              floor_d = rd33;
              cnt_d   = '0;
              pend_d  = 1'b0;
              found_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      FSM_ORDER: begin
        if (better) begin
          found_d = 1'b1;
          fidx_d  = pidx_q;
          fval_d  = rdata;
        end
        if (scan_done && found_q) begin
          res_status_d = ST_OK;
          res_slot_d   = SLOT_IO_W'({1'b0, fidx_q});
          res_id_d     = fval_q;
        end
      end
      FSM_MAXSCAN: begin
        if (pend_q && rdata > high_q) high_d = rdata;
      end
      FSM_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_id_d     = res_id_q;
          out_live_d   = live_q;
        end
      end
      default: ;
    endcase

    if (do_add) begin
      if (add_bad) begin
        res_status_d = ST_NOTFOUND;
      end else if (add_full) begin
        res_status_d = ST_FULL;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = used_q[SLOT_W-1:0];
        mem_wdata = add_id[ID_W-1:0];
        dense_d   = dense_q && !add_leave;
        if (dense_q && live_q == '0) low_d = add_id[ID_W-1:0];
        if (dense_q && !add_leave) begin
          high_d = add_id[ID_W-1:0];
          hint_d = add_id + HINT_ONE;
        end else begin
          if (add_id > high33) high_d = add_id[ID_W-1:0];
          if (add_id == hint_q) hint_d = hint_q + HINT_ONE;
        end
        live_d       = live_q + LIVE_W'(1);
        used_d       = used_q + CNT_W'(1);
        res_status_d = ST_OK;
        res_slot_d   = SLOT_IO_W'(used_q);
        res_id_d     = add_id[ID_W-1:0];
      end
    end

    if (do_drop) begin
      mem_we    = 1'b1;
      mem_waddr = drop_slot;
      mem_wdata = '1;
      dense_d   = 1'b0;
      if (drop_val33 <= hint_q) hint_d = drop_val33;
      live_d = live_q - LIVE_W'(1);
      cnt_d  = '0;
      pend_d = 1'b0;
      if (drop_val == high_q) begin
        high_d = '1;
        if (drop_last) begin
          low_d  = '1;
          hint_d = HINT_ONE;
        end
      end
      res_status_d = ST_OK;
      res_slot_d   = SLOT_IO_W'({1'b0, drop_slot});
      res_id_d     = drop_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      used_q      <= '0;
      live_q      <= '0;
      low_q       <= '1;
      high_q      <= '1;
      hint_q      <= HINT_ONE;
      dense_q     <= 1'b1;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      live_q      <= live_d;
      low_q       <= low_d;
      high_q      <= high_d;
      hint_q      <= hint_d;
      dense_q     <= dense_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    sin_q        <= sin_d;
    pidx_q       <= pidx_d;
    fidx_q       <= fidx_d;
    fval_q       <= fval_d;
    floor_q      <= floor_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_id_q     <= out_id_d;
    out_live_q   <= out_live_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_slot_out_o   = out_slot_q;
  assign out_id_out_o     = out_id_q;
  assign out_live_count_o = out_live_q;

endmodule
`default_nettype wire

### tb/identifier_slot_table_checker.sv
`default_nettype none
module identifier_slot_table_checker import isl_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_i,
  input  wire logic [3:0]                  in_op_i,
  input  wire logic signed [ID_W-1:0]      in_key_id_i,
  input  wire logic signed [SLOT_IO_W-1:0] in_slot_in_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_stall_i,
  input  wire logic [1:0]                  out_status_i,
  input  wire logic signed [SLOT_IO_W-1:0] out_slot_out_i,
  input  wire logic signed [ID_W-1:0]      out_id_out_i,
  input  wire logic [LIVE_W-1:0]           out_live_count_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint IdMax   = 64'sd2147483647;
  localparam longint WideMax = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]                  status;
    logic signed [SLOT_IO_W-1:0] slot;
    logic signed [ID_W-1:0]      id;
    logic [LIVE_W-1:0]           live;
  } table_result_t;

  // Shadow copy of the table.
  longint ids_q [MAX_SLOTS];
  int     used_q;
  int     live_q;
  longint low_q;
  longint high_q;
  longint hint_q;
  bit     dense_q;

  table_result_t pending_results[$];

  function automatic longint inc_sat(longint x);
    return (x < WideMax) ? x + 1 : x;
  endfunction

  function automatic int slot_of_id(longint id);
    if (id < 0 || id > IdMax) return -1;
    for (int i = 0; i < used_q; i++)
      if (ids_q[i] == id) return i;
    return -1;
  endfunction

  function automatic longint id_at(int s);
    if (s < 0 || s >= used_q) return -1;
    return ids_q[s];
  endfunction

  function automatic logic [1:0] append_id(longint id, output int s);
    s = -1;
    if (id < 0 || id > IdMax) return ST_NOTFOUND;
    if (used_q >= MAX_SLOTS) return ST_FULL;
    if (dense_q) begin
      if (live_q == 0) low_q = id;
      else if (id < low_q || id > inc_sat(high_q)) dense_q = 0;
    end
    s = used_q;
    ids_q[s] = id;
    if (dense_q) begin
      high_q = id;
      hint_q = inc_sat(id);
    end else begin
      if (id > high_q) high_q = id;
      if (id == hint_q) hint_q = inc_sat(hint_q);
    end
    live_q++;
    used_q++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] drop_slot(int s, output longint gone);
    longint id;
    gone = -1;
    if (s < 0 || s >= used_q) return ST_NOTFOUND;
    dense_q = 0;
    id = ids_q[s];
    if (id < 0) return ST_NOTFOUND;
    ids_q[s] = -1;
    if (id <= hint_q) hint_q = id;
    live_q--;
    if (id == high_q) begin
      if (live_q == 0) begin
        low_q = -1;
        high_q = -1;
        hint_q = 1;
      end else begin
        high_q = -1;
        for (int i = 0; i < used_q; i++)
          if (ids_q[i] > high_q) high_q = ids_q[i];
      end
    end
    gone = id;
    return ST_OK;
  endfunction

  function automatic int next_live_above(longint floor_id);
    int     best;
    longint best_id;
    best = -1;
    best_id = 0;
    for (int i = 0; i < used_q; i++)
      if (ids_q[i] >= 0 && ids_q[i] > floor_id && (best < 0 || ids_q[i] < best_id)) begin
        best = i;
        best_id = ids_q[i];
      end
    return best;
  endfunction

  function automatic table_result_t apply_op(logic [3:0] op, longint key, int sin);
    table_result_t r;
    logic [1:0] st;
    int         s;
    longint     id;
    st = ST_NOTFOUND;
    s = -1;
    id = -1;
    case (op)
      OP_CREATE_NEXT: begin
        if (hint_q != inc_sat(high_q))
          for (int n = 0; n <= MAX_SLOTS && slot_of_id(hint_q) >= 0; n++)
            hint_q = inc_sat(hint_q);
        st = append_id(hint_q, s);
        if (st == ST_OK) id = ids_q[s];
      end
      OP_CREATE_ID: begin
        if (slot_of_id(key) >= 0) st = ST_IN_USE;
        else begin
          st = append_id(key, s);
          id = key;
        end
      end
      OP_FIND_OR_CREATE: begin
        s = slot_of_id(key);
        if (s >= 0) st = ST_OK;
        else st = append_id(key, s);
        id = key;
      end
      OP_FIND: begin
        s = slot_of_id(key);
        if (s >= 0) st = ST_OK;
        id = key;
      end
      OP_REMOVE_SLOT: begin
        st = drop_slot(sin, id);
        s = sin;
      end
      OP_REMOVE_ID: begin
        s = slot_of_id(key);
        if (s >= 0) st = drop_slot(s, id);
      end
      OP_READ_ID: begin
        id = id_at(sin);
        if (id >= 0) begin
          st = ST_OK;
          s = sin;
        end
      end
      OP_FIRST: begin
        if (live_q != 0) begin
          s = next_live_above(-1);
          if (s >= 0) begin
            st = ST_OK;
            id = ids_q[s];
          end
        end
      end
      OP_NEXT: begin
        id = id_at(sin);
        if (id >= 0) begin
          s = next_live_above(id);
          if (s >= 0) begin
            st = ST_OK;
            id = ids_q[s];
          end
        end
      end
      default: ;
    endcase
    if (st != ST_OK) begin
      s = -1;
      id = -1;
    end
    r.status = st;
    r.slot = SLOT_IO_W'(s);
    r.id = ID_W'(id);
    r.live = LIVE_W'(live_q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t exp_r;
    if (!rst_ni) begin
      foreach (ids_q[i]) ids_q[i] = 0;
      used_q = 0;
      live_q = 0;
      low_q = -1;
      high_q = -1;
      hint_q = 1;
      dense_q = 1;
      pending_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result beat with nothing expected", $realtime);
        end else begin
          exp_r = pending_results.pop_front();
          if (exp_r.status !== out_status_i || exp_r.slot !== out_slot_out_i ||
              exp_r.id !== out_id_out_i || exp_r.live !== out_live_count_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: mismatch exp st=%0d slot=%0d id=%0d live=%0d",
                        " got st=%0d slot=%0d id=%0d live=%0d"},
                       $realtime, exp_r.status, exp_r.slot, exp_r.id, exp_r.live,
                       out_status_i, out_slot_out_i, out_id_out_i, out_live_count_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(apply_op(in_op_i, longint'(in_key_id_i),
                                           int'(in_slot_in_i)));
      pending_o = pending_results.size();
    end
  end

endmodule
`default_nettype wire

### tb/tb_identifier_slot_table_core.sv
`default_nettype none
module tb_identifier_slot_table_core import isl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 30_000_000;
  localparam int DrainWait  = 2 * MAX_SLOTS + 100;

  logic                        clk_i = 0;
  logic                        rst_ni = 0;
  logic                        in_valid_i = 0;
  logic                        in_stall_o;
  logic [3:0]                  in_op_i = '0;
  logic signed [ID_W-1:0]      in_key_id_i = '0;
  logic signed [SLOT_IO_W-1:0] in_slot_in_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 0;
  logic [1:0]                  out_status_o;
  logic signed [SLOT_IO_W-1:0] out_slot_out_o;
  logic signed [ID_W-1:0]      out_id_out_o;
  logic [LIVE_W-1:0]           out_live_count_o;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int stall_left = 0;

  identifier_slot_table_core DUT (.*);

  identifier_slot_table_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i(in_stall_o), .in_op_i, .in_key_id_i, .in_slot_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_status_i(out_status_o),
    .out_slot_out_i(out_slot_out_o), .out_id_out_i(out_id_out_o),
    .out_live_count_i(out_live_count_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Bit 9 of the cycle counter switches the receiver between random stalls and never stalling.
  always @(negedge clk_i) begin
    if (cycle_cnt[9]) begin
      out_stall_i <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 0;
      if ($urandom_range(0, 5) == 0) stall_left <= gap_len();
    end
  end

  task automatic send_beat(logic [3:0] op, int key, int sl);
    bit stalled;
    int gap;
    gap = cycle_cnt[10] ? 0 : gap_len();
    repeat (gap) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_op_i <= op;
    in_key_id_i <= ID_W'(key);
    in_slot_in_i <= SLOT_IO_W'(sl);
    forever begin
      #0.9 stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  function automatic int rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 300);
    if (r < 90) return $urandom();
    return 32'sh7FFF_FFFF - $urandom_range(0, 3);
  endfunction

  function automatic logic [3:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return OP_CREATE_NEXT;
    if (r < 24) return OP_CREATE_ID;
    if (r < 36) return OP_FIND_OR_CREATE;
    if (r < 46) return OP_FIND;
    if (r < 56) return OP_REMOVE_SLOT;
    if (r < 66) return OP_REMOVE_ID;
    if (r < 76) return OP_READ_ID;
    if (r < 82) return OP_FIRST;
    if (r < 96) return OP_NEXT;
    return 4'($urandom_range(9, 15));
  endfunction

  initial begin
    int sl;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Operations on an empty table.
    send_beat(OP_FIRST, 0, 0);
    send_beat(OP_NEXT, 0, -1);
    send_beat(OP_READ_ID, 0, 0);
    send_beat(OP_FIND, 0, 0);
    send_beat(OP_REMOVE_SLOT, 0, 0);
    // Contiguous appends, then a duplicate, a negative key and a jump out of the run.
    send_beat(OP_CREATE_NEXT, 0, 0);
    send_beat(OP_CREATE_NEXT, 0, 0);
    send_beat(OP_CREATE_ID, 3, 0);
    send_beat(OP_CREATE_ID, 3, 0);
    send_beat(OP_CREATE_ID, -5, 0);
    send_beat(OP_FIND_OR_CREATE, 3, 0);
    send_beat(OP_FIND_OR_CREATE, 10, 0);
    send_beat(OP_FIND, 32'sh7FFF_FFFF, 0);
    send_beat(OP_FIND, 32'sh8000_0000, 0);
    send_beat(OP_READ_ID, 0, 1);
    send_beat(OP_READ_ID, 0, 1023);
    send_beat(OP_READ_ID, 0, 11'sh400);
    send_beat(OP_FIRST, 0, 0);
    send_beat(OP_NEXT, 0, 0);
    send_beat(OP_NEXT, 0, 3);
    send_beat(OP_REMOVE_SLOT, 0, 1);
    send_beat(OP_REMOVE_SLOT, 0, 1);
    send_beat(OP_REMOVE_ID, 10, 0);
    send_beat(OP_REMOVE_ID, 10, 0);
    send_beat(4'd9, 32'sh7FFF_FFFF, 11'sh3FF);
    send_beat(4'd15, -1, -1);
    send_beat(OP_CREATE_NEXT, 0, 0);

    for (int i = 0; i < 360; i++) begin
      if (i == 180) wait_drained();
      sl = ($urandom_range(0, 9) == 0) ? int'($urandom()) : int'($urandom_range(0, 200));
      send_beat(rand_op(), rand_key(), sl);
    end

    // A few checks on whatever the random phase left behind.
    wait_drained();
    send_beat(OP_CREATE_NEXT, 0, 0);
    send_beat(OP_FIND_OR_CREATE, 2_000_000, 0);
    send_beat(OP_FIND, 2_000_000, 0);
    send_beat(OP_READ_ID, 0, 1023);
    send_beat(OP_REMOVE_SLOT, 0, 1023);
    send_beat(OP_CREATE_NEXT, 0, 0);
    send_beat(OP_FIRST, 0, 0);
    send_beat(OP_NEXT, 0, 1000);

    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
